### sv/tfsm_pkg.sv
// package for the telemetry frame sync and median filter
// constants, history entry type, sequencer states and crc step; no dependencies
package tfsm_pkg;

  localparam int unsigned FRAME_LEN   = 10;
  localparam int unsigned CRC_LEN     = 9;
  localparam int unsigned HIST_DEPTH  = 11;
  localparam int unsigned HIST_IDX_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int unsigned HIST_CNT_W  = $clog2(HIST_DEPTH + 1);
  localparam logic [15:0] SCALE_RESET = 16'd16384;
  localparam logic [31:0] PROD_MIN    = 32'd8192000;   // 500 * 16384
  localparam logic [31:0] PROD_MAX    = 32'd49152000;  // 3000 * 16384
  localparam logic [13:0] CUR_MAX     = 14'd10000;
  localparam logic [7:0]  TEMP_MIN    = 8'd10;
  localparam logic [7:0]  TEMP_MAX    = 8'd120;
  localparam logic [15:0] ERPM_MAX    = 16'd3000;
  localparam logic [7:0]  CRC_POLY    = 8'h07;

  // frame status codes
  localparam logic [1:0] ST_PARTIAL  = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_CRC_BAD  = 2'd2;
  localparam logic [1:0] ST_IMPLAUS  = 2'd3;

  typedef struct packed {
    logic [6:0]  temp;
    logic [11:0] volt;
    logic [13:0] cur;
    logic [15:0] cons;
    logic [11:0] erpm;
  } hist_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_MUL,
    S_CHK,
    S_LOAD,
    S_SWEEP,
    S_DONE
  } state_t;

  // one byte of msb-first crc-8, no reflection
  function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

### sv/telemetry_frame_sync_median.sv
// a short window goes straight to its result; a full window runs the crc over its first nine
// bytes and ends on a mismatch, else the scaled voltage product is registered and checked:
// an implausible frame ends there, an accepted one is stored in the history and the medians
// are swept over the n filled entries. one byte at a time: ready again only after its result
// is loaded into the output register once the last result is taken. reset (rst_n low, synchronous)
// empties window and history, clears counters and medians, and sets the voltage scale to 1.0
module telemetry_frame_sync_median
  import tfsm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // rx_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // frame_status, have_data, median_temperature, median_voltage_cv, median_current_ca,
  // median_consumption, median_erpm, accepted_count, rejected_count, byte_count
  output logic [159:0] out_tdata,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  state_t state_r, state_nxt;

  logic [7:0]  win_r [FRAME_LEN];
  logic [3:0]  fill_r;
  logic [3:0]  k_r;
  logic [7:0]  crc_r;
  logic [31:0] prod_r;
  logic [1:0]  status_r;
  logic [15:0] scale_r;
  hist_t       hist_r [HIST_DEPTH];
  logic [HIST_IDX_W-1:0] slot_r;
  logic [HIST_CNT_W-1:0] entries_r;
  logic [HIST_IDX_W-1:0] i_r, j_r;
  hist_t       cand_r, med_r;
  logic [HIST_CNT_W-1:0] lt_r [5];
  logic [HIST_CNT_W-1:0] le_r [5];
  logic [31:0] acc_cnt_r, rej_cnt_r, byte_cnt_r;
  logic        out_tvalid_r;
  logic [159:0] out_tdata_r;

  logic        in_acc;
  logic [3:0]  wr_pos;
  logic [7:0]  crc_fin;
  logic        plausible;
  hist_t       rd_ent;
  logic [HIST_IDX_W-1:0] rd_idx;
  logic [HIST_CNT_W-1:0] half;
  logic [HIST_CNT_W-1:0] lt_nxt [5];
  logic [HIST_CNT_W-1:0] le_nxt [5];
  logic [4:0]  hit;
  logic        out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_free   = !out_tvalid_r || out_tready;
  assign wr_pos     = (fill_r >= 4'(FRAME_LEN)) ? 4'(FRAME_LEN - 1) : fill_r;
  assign crc_fin    = crc_step(crc_r, win_r[k_r]);
  assign half       = entries_r >> 1;

  // plausibility on the registered product
  assign plausible = (prod_r >= PROD_MIN) && (prod_r <= PROD_MAX)
                   && ({win_r[3], win_r[4]} <= {2'b00, CUR_MAX})
                   && (win_r[0] >= TEMP_MIN) && (win_r[0] <= TEMP_MAX)
                   && ({win_r[7], win_r[8]} <= ERPM_MAX);

  // single history read port: candidate on load, sweep element otherwise
  assign rd_idx = (state_r == S_LOAD) ? i_r : j_r;
  assign rd_ent = hist_r[rd_idx];

  // shared compare lanes, one per field
  always_comb begin
    logic [4:0] lt, eq;
    lt[0] = rd_ent.temp < cand_r.temp;  eq[0] = rd_ent.temp == cand_r.temp;
    lt[1] = rd_ent.volt < cand_r.volt;  eq[1] = rd_ent.volt == cand_r.volt;
    lt[2] = rd_ent.cur  < cand_r.cur;   eq[2] = rd_ent.cur  == cand_r.cur;
    lt[3] = rd_ent.cons < cand_r.cons;  eq[3] = rd_ent.cons == cand_r.cons;
    lt[4] = rd_ent.erpm < cand_r.erpm;  eq[4] = rd_ent.erpm == cand_r.erpm;
    for (int f = 0; f < 5; f++) begin
      lt_nxt[f] = lt_r[f] + HIST_CNT_W'(lt[f]);
      le_nxt[f] = le_r[f] + HIST_CNT_W'(lt[f] | eq[f]);
      hit[f]    = (lt_nxt[f] <= half) && (le_nxt[f] > half);
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = (wr_pos == 4'(FRAME_LEN - 1)) ? S_CRC : S_DONE;
      S_CRC:   if (k_r == 4'(CRC_LEN - 1)) begin
                 state_nxt = (crc_fin != win_r[FRAME_LEN-1]) ? S_DONE : S_MUL;
               end
      S_MUL:   state_nxt = S_CHK;
      S_CHK:   state_nxt = plausible ? S_LOAD : S_DONE;
      S_LOAD:  state_nxt = S_SWEEP;
      S_SWEEP: if (HIST_CNT_W'(j_r) == entries_r - 1'b1) begin
                 state_nxt = (HIST_CNT_W'(i_r) == entries_r - 1'b1) ? S_DONE : S_LOAD;
               end
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n)         scale_r <= SCALE_RESET;
    else if (cfg_wr_en) scale_r <= cfg_wr_data;
  end

  // window, crc, check and history datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      slot_r     <= '0;
      entries_r  <= '0;
      med_r      <= '0;
      acc_cnt_r  <= '0;
      rej_cnt_r  <= '0;
      byte_cnt_r <= '0;
      status_r   <= ST_PARTIAL;
    end else begin
      case (state_r)
        S_IDLE: if (in_acc) begin
          win_r[wr_pos] <= in_tdata;
          fill_r        <= wr_pos + 4'd1;
          byte_cnt_r    <= byte_cnt_r + 32'd1;
          status_r      <= ST_PARTIAL;
          k_r           <= '0;
          crc_r         <= '0;
        end
        S_CRC: begin
          crc_r <= crc_fin;
          k_r   <= k_r + 4'd1;
          if (k_r == 4'(CRC_LEN - 1) && crc_fin != win_r[FRAME_LEN-1]) begin
            status_r  <= ST_CRC_BAD;
            rej_cnt_r <= rej_cnt_r + 32'd1;
            for (int b = 0; b < FRAME_LEN - 1; b++) win_r[b] <= win_r[b+1];
            fill_r <= 4'(FRAME_LEN - 1);
          end
        end
        S_MUL: prod_r <= {win_r[1], win_r[2]} * scale_r;
        S_CHK: begin
          if (plausible) begin
            hist_r[slot_r] <= '{temp: win_r[0][6:0], volt: prod_r[25:14],
                                cur: {win_r[3][5:0], win_r[4]},
                                cons: {win_r[5], win_r[6]}, erpm: {win_r[7][3:0], win_r[8]}};
            slot_r    <= (slot_r == HIST_IDX_W'(HIST_DEPTH - 1)) ? '0 : slot_r + 1'b1;
            if (entries_r != HIST_CNT_W'(HIST_DEPTH)) entries_r <= entries_r + 1'b1;
            status_r  <= ST_ACCEPTED;
            acc_cnt_r <= acc_cnt_r + 32'd1;
            fill_r    <= '0;
            i_r       <= '0;
          end else begin
            status_r  <= ST_IMPLAUS;
            rej_cnt_r <= rej_cnt_r + 32'd1;
            for (int b = 0; b < FRAME_LEN - 1; b++) win_r[b] <= win_r[b+1];
            fill_r <= 4'(FRAME_LEN - 1);
          end
        end
        S_LOAD: begin
          cand_r <= rd_ent;
          j_r    <= '0;
          for (int f = 0; f < 5; f++) begin
            lt_r[f] <= '0;
            le_r[f] <= '0;
          end
        end
        S_SWEEP: begin
          for (int f = 0; f < 5; f++) begin
            lt_r[f] <= lt_nxt[f];
            le_r[f] <= le_nxt[f];
          end
          j_r <= j_r + 1'b1;
          if (HIST_CNT_W'(j_r) == entries_r - 1'b1) begin
            i_r <= i_r + 1'b1;
            if (hit[0]) med_r.temp <= cand_r.temp;
            if (hit[1]) med_r.volt <= cand_r.volt;
            if (hit[2]) med_r.cur  <= cand_r.cur;
            if (hit[3]) med_r.cons <= cand_r.cons;
            if (hit[4]) med_r.erpm <= cand_r.erpm;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_tvalid_r <= 1'b1;
      out_tdata_r  <= {byte_cnt_r, rej_cnt_r, acc_cnt_r, med_r.erpm, med_r.cons, med_r.cur,
                       med_r.volt, med_r.temp, (entries_r != '0), status_r};
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("ready while busy");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 4'(FRAME_LEN)) else $error("window fill out of range");
  a_entries_range: assert property (@(posedge clk) disable iff (!rst_n)
    entries_r <= HIST_CNT_W'(HIST_DEPTH)) else $error("history count out of range");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready) else $error("beat accepted without processing");
`endif

endmodule
